/* src/sps_pkg.sv */
// Shared types and codes for the sorted point table search block.
// Depends on nothing; used by sorted_point_table_search.
package sps_pkg;

  localparam int COORD_W  = 32;
  localparam int CMD_W    = 3;
  localparam int INDEX_W  = 10;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 2 * COORD_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_MEMBER = 3'd1,
    CMD_SUCC   = 3'd2,
    CMD_PRED   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_EVAL,
    S_DONE
  } state_t;

endpackage

/* src/sorted_point_table_search.sv */
// Sorted point table search: point memory, binary search sequencer, result register.
// Depends on sps_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: command,
//   point_x, point_y (signed Q16.16). Output channel (out_valid / out_stall)
//   returns exactly one result beat per command: found, index, status.
//   Append writes the point at the end of the table (status 2 if full);
//   clear empties the table. Membership, successor and predecessor queries
//   run a binary search over the point memory.
//   Timing: append, clear and unused codes go from acceptance straight to the
//   final state, which loads the output register, and then back to idle for the
//   next command. A query passes S_PROBE and S_EVAL for every probe, since
//   every probe waits for the registered memory read; with n entries a search
//   makes at most floor(log2(n))+1 probes, and the query holds the input until
//   its result beat is loaded into the output register.
//   One command is in work at a time; in_stall is high while it runs.
//   A finished result sits in the output register; the next command is
//   accepted while that beat waits. If out_stall holds, the following
//   result waits in its final state, with in_stall high, until the output
//   register frees up.
//   Reset (rst, synchronous) empties the table and drops any pending beat;
//   memory contents are not cleared, only the entry count.
module sorted_point_table_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sps_pkg::CMD_W-1:0]          command,
  input  logic signed [sps_pkg::COORD_W-1:0] point_x,
  input  logic signed [sps_pkg::COORD_W-1:0] point_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [sps_pkg::INDEX_W-1:0]        index,
  output logic [sps_pkg::STATUS_W-1:0]       status
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;  // address width
  localparam int CW = $clog2(TABLE_DEPTH + 1);                       // count width
  localparam int SW = CW + 1;                                        // signed bound width

  // point memory: x in upper half, y in lower half
  logic [sps_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [sps_pkg::ENTRY_W-1:0] rd_a;  // entry at mid
  logic [sps_pkg::ENTRY_W-1:0] rd_b;  // neighbor entry (mid-1 or mid+1)
  logic [IW-1:0]               addr_a;
  logic [IW-1:0]               addr_b;
  logic                        mem_we;

  // control and working registers
  sps_pkg::state_t             state, state_next;
  sps_pkg::cmd_t               cmd, cmd_next;
  logic signed [sps_pkg::COORD_W-1:0] qx, qy;
  logic [CW-1:0]               count, count_next;
  logic signed [SW-1:0]        lo, lo_next;
  logic signed [SW-1:0]        hi, hi_next;
  logic signed [SW-1:0]        mid, mid_next;
  logic                        res_found, res_found_next;
  logic [SW-1:0]               res_index, res_index_next;
  sps_pkg::status_t            res_status, res_status_next;
  logic                        out_load;

  // compare results against query
  logic signed [sps_pkg::COORD_W-1:0] ax, ay, bx, by;
  logic                        a_gt, a_eq, a_lt;
  logic                        b_gt, b_eq, b_lt;
  logic                        in_acc;

  assign in_stall = (state != sps_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign ax = rd_a[sps_pkg::ENTRY_W-1:sps_pkg::COORD_W];
  assign ay = rd_a[sps_pkg::COORD_W-1:0];
  assign bx = rd_b[sps_pkg::ENTRY_W-1:sps_pkg::COORD_W];
  assign by = rd_b[sps_pkg::COORD_W-1:0];

  // lexicographic compare: x first, then y
  assign a_eq = (ax == qx) && (ay == qy);
  assign a_gt = (ax > qx) || ((ax == qx) && (ay > qy));
  assign a_lt = !a_gt && !a_eq;
  assign b_eq = (bx == qx) && (by == qy);
  assign b_gt = (bx > qx) || ((bx == qx) && (by > qy));
  assign b_lt = !b_gt && !b_eq;

  // probe addresses come straight from the midpoint computed in S_PROBE
  always_comb begin
    logic signed [SW-1:0] nb;
    nb = (cmd == sps_pkg::CMD_PRED) ? (mid_next + SW'(1)) : (mid_next - SW'(1));
    addr_a = mid_next[IW-1:0];
    addr_b = nb[IW-1:0];
  end

  // memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IW-1:0]] <= {point_x, point_y};
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // sequencer
  always_comb begin
    logic signed [SW-1:0] cnt_s;
    cnt_s           = signed'({1'b0, count});
    state_next      = state;
    cmd_next        = cmd;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    res_found_next  = res_found;
    res_index_next  = res_index;
    res_status_next = res_status;
    mem_we          = 1'b0;
    out_load        = 1'b0;

    case (state)
      sps_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_next        = sps_pkg::cmd_t'(command);
          res_found_next  = 1'b0;
          res_index_next  = '0;
          res_status_next = sps_pkg::ST_OK;
          state_next      = sps_pkg::S_DONE;
          case (sps_pkg::cmd_t'(command))
            sps_pkg::CMD_APPEND: begin
              if (count >= CW'(TABLE_DEPTH)) begin
                res_status_next = sps_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = count + CW'(1);
              end
            end
            sps_pkg::CMD_MEMBER: begin
              lo_next    = '0;
              hi_next    = cnt_s - SW'(1);
              state_next = sps_pkg::S_PROBE;
            end
            sps_pkg::CMD_SUCC: begin
              if (count == '0) begin
                res_status_next = sps_pkg::ST_EMPTY;
              end else begin
                lo_next        = SW'(1);
                hi_next        = cnt_s - SW'(1);
                res_index_next = SW'(count) - SW'(1);  // no hit: last index
                state_next     = sps_pkg::S_PROBE;
              end
            end
            sps_pkg::CMD_PRED: begin
              if (count == '0) begin
                res_status_next = sps_pkg::ST_EMPTY;
              end else begin
                lo_next    = '0;
                hi_next    = cnt_s - SW'(2);
                state_next = sps_pkg::S_PROBE;
              end
            end
            sps_pkg::CMD_CLEAR: begin
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      sps_pkg::S_PROBE: begin
        if (lo <= hi) begin
          mid_next   = lo + ((hi - lo) >>> 1);
          state_next = sps_pkg::S_EVAL;
        end else begin
          state_next = sps_pkg::S_DONE;
        end
      end

      sps_pkg::S_EVAL: begin
        state_next = sps_pkg::S_PROBE;
        case (cmd)
          sps_pkg::CMD_MEMBER: begin
            if (a_eq) begin
              res_found_next = 1'b1;
              state_next     = sps_pkg::S_DONE;
            end else if (a_gt) begin
              lo_next = mid + SW'(1);
            end else begin
              hi_next = mid - SW'(1);
            end
          end
          sps_pkg::CMD_SUCC: begin
            // rd_b holds mid-1, rd_a holds mid
            if (b_gt && !a_gt) begin
              res_index_next = mid - SW'(1);
              state_next     = sps_pkg::S_DONE;
            end else if (!b_gt) begin
              hi_next = mid - SW'(1);
            end else begin
              lo_next = mid + SW'(1);
            end
          end
          sps_pkg::CMD_PRED: begin
            // rd_b holds mid+1, rd_a holds mid
            if (b_lt && !a_lt) begin
              res_index_next = mid + SW'(1);
              state_next     = sps_pkg::S_DONE;
            end else if (!b_lt) begin
              lo_next = mid + SW'(1);
            end else begin
              hi_next = mid - SW'(1);
            end
          end
          default: begin
            state_next = sps_pkg::S_DONE;
          end
        endcase
      end

      sps_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = sps_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = sps_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sps_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    res_found  <= res_found_next;
    res_index  <= res_index_next;
    res_status <= res_status_next;
    if (in_acc) begin
      qx <= point_x;
      qy <= point_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found  <= res_found;
      index  <= sps_pkg::INDEX_W'(res_index);
      status <= res_status;
    end
  end

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == sps_pkg::S_EVAL) |-> (mid >= lo && mid <= hi))
    else $error("probe midpoint outside search window");

  a_probe_valid_entry: assert property (@(posedge clk) disable iff (rst)
    (state == sps_pkg::S_EVAL) |-> (mid >= 0 && mid < signed'({1'b0, count})))
    else $error("probe reads beyond loaded entries");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == sps_pkg::S_DONE)
    else $error("result beat raised outside final state");

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for sorted_point_table_search: drives append, query and clear beats
// with random idling and back-pressure, and checks each result beat against a shadow table.
// Depends on sps_pkg and sorted_point_table_search.
module testbench;
  import sps_pkg::*;

  localparam int DEPTH           = 1024;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 15;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  // Codes past CMD_CLEAR are not decoded; the block answers them with an all-zero beat.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic                found;
    logic [INDEX_W-1:0]  index;
    status_t             status;
  } answer_t;

  // DUT ports; every input is known from time zero.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               out_stall = 1'b0;
  logic [CMD_W-1:0]   command   = '0;
  coord_t             point_x   = '0;
  coord_t             point_y   = '0;
  logic               in_stall;
  logic               out_valid;
  logic               found;
  logic [INDEX_W-1:0] index;
  logic [STATUS_W-1:0] status;

  // Shadow copy of the point table, updated as each command beat is accepted.
  coord_t  shadow_x [DEPTH];
  coord_t  shadow_y [DEPTH];
  int      shadow_count = 0;

  // Answers owed by the block, oldest first.
  answer_t pending_answers[$];
  answer_t head_answer;

  // Points of the sequence being loaded; queries are drawn near them.
  coord_t  seq_x[$];
  coord_t  seq_y[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  sorted_point_table_search #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .point_x  (point_x),
    .point_y  (point_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found    (found),
    .index    (index),
    .status   (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow table search. Lexicographic compare, x first then y, signed.
  // The probe order matches the hardware so unsorted tables still agree.
  // ---------------------------------------------------------------------------
  function automatic int shadow_compare(int i, coord_t qx, coord_t qy);
    if (shadow_x[i] != qx) return (shadow_x[i] > qx) ? 1 : -1;
    if (shadow_y[i] != qy) return (shadow_y[i] > qy) ? 1 : -1;
    return 0;
  endfunction

  function automatic bit shadow_member(coord_t qx, coord_t qy);
    int lo, hi, mid, c;
    lo = 0;
    hi = shadow_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      c = shadow_compare(mid, qx, qy);
      if (c == 0) return 1'b1;
      if (c > 0) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b0;
  endfunction

  // Last entry greater than the query; last index when none is.
  function automatic int shadow_successor(coord_t qx, coord_t qy);
    int lo, hi, mid, a, b;
    lo = 1;
    hi = shadow_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      a = shadow_compare(mid - 1, qx, qy);
      b = shadow_compare(mid, qx, qy);
      if (a > 0 && b <= 0) return mid - 1;
      if (a <= 0) hi = mid - 1;
      else lo = mid + 1;
    end
    return shadow_count - 1;
  endfunction

  // First entry less than the query; 0 when none is.
  function automatic int shadow_predecessor(coord_t qx, coord_t qy);
    int lo, hi, mid, a, b;
    lo = 0;
    hi = shadow_count - 2;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      a = shadow_compare(mid + 1, qx, qy);
      b = shadow_compare(mid, qx, qy);
      if (a < 0 && b >= 0) return mid + 1;
      if (a >= 0) lo = mid + 1;
      else hi = mid - 1;
    end
    return 0;
  endfunction

  // Applies one command to the shadow table and returns the beat it should produce.
  function automatic answer_t table_answer(logic [CMD_W-1:0] cmd, coord_t qx, coord_t qy);
    answer_t ans;
    ans.found  = 1'b0;
    ans.index  = '0;
    ans.status = ST_OK;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_count >= DEPTH) begin
          ans.status = ST_FULL;     // point is dropped
        end else begin
          shadow_x[shadow_count] = qx;
          shadow_y[shadow_count] = qy;
          shadow_count++;
        end
      end
      CMD_MEMBER: ans.found = shadow_member(qx, qy);
      CMD_SUCC: begin
        if (shadow_count == 0) ans.status = ST_EMPTY;
        else ans.index = INDEX_W'(shadow_successor(qx, qy));
      end
      CMD_PRED: begin
        if (shadow_count == 0) ans.status = ST_EMPTY;
        else ans.index = INDEX_W'(shadow_predecessor(qx, qy));
      end
      CMD_CLEAR: shadow_count = 0;
      default: ;
    endcase
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly full-range random, with the edges of Q16.16 mixed in.
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 15))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      default: return coord_t'($urandom());
    endcase
  endfunction

  // One step away in either direction; wraps at the edges on purpose.
  function automatic coord_t nudge(coord_t v);
    return $urandom_range(0, 1) ? coord_t'(v + 1) : coord_t'(v - 1);
  endfunction

  // Query point: an exact table hit, a near miss next to an entry, or anything.
  task automatic pick_query(output coord_t qx, output coord_t qy);
    int          j;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (seq_x.size() == 0 || sel >= 7) begin
      qx = rand_coord();
      qy = rand_coord();
    end else begin
      j  = $urandom_range(0, seq_x.size() - 1);
      qx = seq_x[j];
      qy = seq_y[j];
      if (sel >= 4) begin
        if ($urandom_range(0, 1)) qx = nudge(qx);
        else qy = nudge(qy);
      end
    end
  endtask

  // Fills seq_x/seq_y with k distinct points in strictly descending order.
  // Either spread over the whole range or packed tight, so near misses land
  // between neighbors. Runs on equal x step y down.
  task automatic build_descending(int k);
    longint span, cx, cy, d;
    seq_x.delete();
    seq_y.delete();
    if ($urandom_range(0, 1)) span = 64'h0000_0000_FFFF_FFFF / (k + 1);
    else span = $urandom_range(1, 8);
    if ($urandom_range(0, 3) == 0) cx = COORD_MAX;
    else cx = longint'(rand_coord());
    // leave room for every x step below the start
    if (cx - (k + 1) * span < COORD_MIN) cx = COORD_MIN + (k + 1) * span;
    cy = longint'(rand_coord());
    for (int i = 0; i < k; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 1)) d = $urandom_range(1, 4);
        else d = $urandom_range(1, 1 << 20);
        if ($urandom_range(0, 2) == 0 && cy - d >= COORD_MIN) begin
          cy = cy - d;
        end else begin
          d  = $urandom_range(1, 32'(span));
          cx = cx - d;
          cy = longint'(rand_coord());
        end
      end
      seq_x = {seq_x, coord_t'(cx)};
      seq_y = {seq_y, coord_t'(cy)};
    end
  endtask

  // Offers one beat, idling first at the current rate, and holds it until taken.
  // Valid is only lowered inside the idle loop, so back-to-back beats never
  // see a low-then-high in one step.
  task automatic send_beat(logic [CMD_W-1:0] cmd, coord_t qx, coord_t qy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    point_x  <= qx;
    point_y  <= qy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_answers = {pending_answers, table_answer(cmd, qx, qy)};
    items_sent++;
  endtask

  task automatic set_idling(int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    stall_pct     = receiver_pct;
  endtask

  // Clear, load a sorted table, then query it. Now and then the clear is
  // skipped so the new points land after old ones and the table is unsorted.
  task automatic run_sorted_sequence();
    int               k;
    logic [CMD_W-1:0] cmd;
    coord_t           qx, qy;
    if ($urandom_range(0, 9) == 0) k = $urandom_range(30, 60);
    else k = $urandom_range(0, 24);
    build_descending(k);
    if ($urandom_range(0, 7) != 0) send_beat(CMD_CLEAR, rand_coord(), rand_coord());
    foreach (seq_x[i]) send_beat(CMD_APPEND, seq_x[i], seq_y[i]);
    repeat ($urandom_range(4, 20)) begin
      pick_query(qx, qy);
      case ($urandom_range(0, 19))
        0: cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
        1: cmd = CMD_APPEND;    // stray point, breaks the order
        default: cmd = CMD_W'($urandom_range(CMD_MEMBER, CMD_PRED));
      endcase
      send_beat(cmd, qx, qy);
    end
  endtask

  // Any code, any point: duplicates, out-of-order loads, stray clears.
  task automatic run_noise();
    logic [CMD_W-1:0] cmd;
    coord_t           qx, qy;
    repeat ($urandom_range(5, 20)) begin
      cmd = CMD_W'($urandom_range(CMD_APPEND, CMD_LAST_UNUSED));
      pick_query(qx, qy);
      if (cmd == CMD_APPEND) begin
        seq_x = {seq_x, qx};
        seq_y = {seq_y, qy};
      end
      send_beat(cmd, qx, qy);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Queries on the empty table after reset, clear, and the undecoded codes.
  task automatic test_empty_table();
    send_beat(CMD_MEMBER, '0, '0);
    send_beat(CMD_SUCC, COORD_MAX, COORD_MAX);
    send_beat(CMD_PRED, COORD_MIN, COORD_MIN);
    send_beat(CMD_CLEAR, COORD_MAX, COORD_MIN);
    send_beat(CMD_FIRST_UNUSED, COORD_MAX, COORD_MAX);
    send_beat(CMD_W'(CMD_FIRST_UNUSED + 1), COORD_MIN, COORD_MAX);
    send_beat(CMD_LAST_UNUSED, COORD_MIN, COORD_MIN);
  endtask

  // Corners of the coordinate space, searches off both ends, one-entry table.
  task automatic test_extreme_points();
    send_beat(CMD_APPEND, COORD_MAX, COORD_MAX);
    send_beat(CMD_APPEND, COORD_MAX, COORD_MIN);
    send_beat(CMD_APPEND, '0, '0);
    send_beat(CMD_APPEND, COORD_MIN, COORD_MAX);
    send_beat(CMD_APPEND, COORD_MIN, COORD_MIN);
    send_beat(CMD_MEMBER, COORD_MAX, COORD_MIN);
    send_beat(CMD_MEMBER, '0, coord_t'(1));
    send_beat(CMD_MEMBER, COORD_MIN, COORD_MIN);
    send_beat(CMD_SUCC, COORD_MAX, COORD_MAX);
    send_beat(CMD_SUCC, '0, '0);
    send_beat(CMD_SUCC, COORD_MIN, COORD_MIN);
    send_beat(CMD_PRED, COORD_MAX, COORD_MAX);
    send_beat(CMD_PRED, '0, coord_t'(-1));
    send_beat(CMD_PRED, COORD_MIN, COORD_MIN);
    // single entry: both searches have nothing to probe
    send_beat(CMD_CLEAR, '0, '0);
    send_beat(CMD_APPEND, coord_t'(1), coord_t'(1));
    send_beat(CMD_SUCC, '0, '0);
    send_beat(CMD_PRED, COORD_MAX, '0);
  endtask

  task automatic test_random_traffic(int budget);
    int target;
    target = items_sent + budget;
    while (items_sent < target) begin
      if ($urandom_range(0, 6) == 0) run_noise();
      else run_sorted_sequence();
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering:
  // the output register and the finished search fill, then in_stall rises.
  task automatic test_backpressure();
    coord_t qx, qy;
    in_valid <= 1'b0;
    @(negedge clk);
    hold_request = HOLD_CYCLES;
    @(posedge clk);
    build_descending(8);
    send_beat(CMD_CLEAR, '0, '0);
    foreach (seq_x[i]) send_beat(CMD_APPEND, seq_x[i], seq_y[i]);
    repeat (6) begin
      pick_query(qx, qy);
      send_beat(CMD_W'($urandom_range(CMD_MEMBER, CMD_PRED)), qx, qy);
    end
  endtask

  // Load every slot, overflow twice, then search the full table.
  task automatic test_full_table();
    coord_t qx, qy;
    build_descending(DEPTH);
    send_beat(CMD_CLEAR, '0, '0);
    foreach (seq_x[i]) send_beat(CMD_APPEND, seq_x[i], seq_y[i]);
    repeat (2) send_beat(CMD_APPEND, rand_coord(), rand_coord());
    repeat (12) begin
      pick_query(qx, qy);
      send_beat(CMD_W'($urandom_range(CMD_MEMBER, CMD_PRED)), qx, qy);
    end
    send_beat(CMD_SUCC, COORD_MIN, COORD_MIN);
    send_beat(CMD_PRED, COORD_MAX, COORD_MAX);
    send_beat(CMD_MEMBER, seq_x[DEPTH-1], seq_y[DEPTH-1]);
    send_beat(CMD_CLEAR, '0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall at the current rate, or a counted hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result checker: every accepted result beat against the oldest answer owed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with nothing outstanding: found %0d index %0d status %0d",
               found, index, status);
        mismatch_count++;
      end else begin
        head_answer = pending_answers.pop_front();
        if (found !== head_answer.found) begin
          $error("found: expected %0d, actual %0d", head_answer.found, found);
          mismatch_count++;
        end
        if (index !== head_answer.index) begin
          $error("index: expected %0d, actual %0d", head_answer.index, index);
          mismatch_count++;
        end
        if (status !== head_answer.status) begin
          $error("status: expected %0d, actual %0d", head_answer.status, status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hang ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Sequence of tests. Idling: sender 20 / receiver 70, then 70 / 20, then none.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_idling(20, 70);
    test_empty_table();
    test_extreme_points();
    test_random_traffic(ITEMS_PER_PHASE);
    test_backpressure();
    set_idling(70, 20);
    test_random_traffic(ITEMS_PER_PHASE);
    set_idling(0, 0);
    test_full_table();
    test_random_traffic(ITEMS_PER_PHASE);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
